// ----- hw/rtl/dsfg_pkg.sv -----
// Shared constants, types and state encoding for the drum sample filter and fade gate.
package dsfg_pkg;

  localparam int SAMPLE_W = 24;
  localparam int INDEX_W  = 21;

  // Coefficients are unsigned Q1.16, gate values unsigned Q0.24 / Q1.24
  localparam int COEF_W = 17;
  localparam int STEP_W = 24;
  localparam int GAIN_W = 25;
  localparam int CFG_W  = (INDEX_W > STEP_W) ? INDEX_W : STEP_W;
  localparam int CFG_IDX_W = 3;

  // Shared multiplier operand widths: A carries samples/differences, B gains
  localparam int MA_W = (SAMPLE_W + 2 > INDEX_W + 1) ? SAMPLE_W + 2 : INDEX_W + 1;
  localparam int MB_W = GAIN_W + 1;
  localparam int P_W  = MA_W + MB_W;

  localparam logic [COEF_W-1:0] UNITY_Q16 = COEF_W'(65536);
  localparam logic [GAIN_W-1:0] UNITY_Q24 = GAIN_W'(1) << 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HP_ENABLE   = 3'd0,
    REG_HP_COEFF    = 3'd1,
    REG_LP_COEFF    = 3'd2,
    REG_SHELF_GAIN  = 3'd3,
    REG_GATE_ENABLE = 3'd4,
    REG_GATE_START  = 3'd5,
    REG_GATE_END    = 3'd6,
    REG_GATE_STEP   = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HP_MUL,
    S_HP_ACC,
    S_LP_MUL,
    S_LP_ACC,
    S_SH_MUL,
    S_SH_ACC,
    S_GD_MUL,
    S_GD_ACC,
    S_GG_MUL,
    S_GG_ACC
  } state_t;

endpackage

// ----- hw/rtl/dsfg_in_if.sv -----
// Sample input channel: valid/ready with sample and first-of-buffer flag.
interface dsfg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dsfg_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 first;

  modport source (output valid, output sample_in, output first, input ready);
  modport sink   (input valid, input sample_in, input first, output ready);
endinterface

// ----- hw/rtl/dsfg_out_if.sv -----
// Sample output channel: valid/ready with the processed sample.
interface dsfg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dsfg_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- hw/rtl/dsfg_cfg_if.sv -----
// Configuration write channel: valid/ready with register index and write data.
interface dsfg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dsfg_pkg::CFG_IDX_W-1:0]    index;
  logic [dsfg_pkg::CFG_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/dsfg_mul.sv -----
// Shared signed multiplier with registered product.
module dsfg_mul (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [dsfg_pkg::MA_W-1:0]   a,
  input  logic signed [dsfg_pkg::MB_W-1:0]   b,
  output logic signed [dsfg_pkg::P_W-1:0]    p
);

  logic signed [dsfg_pkg::P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= dsfg_pkg::P_W'(a) * dsfg_pkg::P_W'(b);
    end
  end

  assign p = p_r;

endmodule

// ----- hw/rtl/drum_sample_filter_and_fade_gate_unit.sv -----
// Top level: high-pass, high-shelf cut and tail fade gate on one shared multiplier.
//
//  channel | dir | signals                    | transaction when
//  in_ch   | in  | sample_in[23:0], first     | valid && ready
//  out_ch  | out | sample_out[23:0]           | valid && ready
//  cfg_ch  | in  | index[2:0], data[23:0]     | valid && ready (ready always high)
//
// Each accepted sample runs through five multiply/accumulate pairs in turn on the
// one multiplier before its result is registered; a new sample is accepted only
// once the sequencer is back in its idle state.
// in_ch.ready is high only in the idle state; the output register lets a new
// sample be taken while the previous result waits. A stalled output holds the
// sequencer in its last step. Reset (rst_n low, synchronous) restores the
// register defaults and clears the filter state and sample index.
module drum_sample_filter_and_fade_gate_unit (
  input logic        clk,
  input logic        rst_n,
  dsfg_in_if.sink    in_ch,
  dsfg_out_if.source out_ch,
  dsfg_cfg_if.sink   cfg_ch
);

  localparam int SW = dsfg_pkg::SAMPLE_W;
  localparam int IW = dsfg_pkg::INDEX_W;
  localparam int PW = dsfg_pkg::P_W;
  localparam int AW = dsfg_pkg::MA_W;
  localparam int BW = dsfg_pkg::MB_W;
  localparam int CW = dsfg_pkg::COEF_W;
  localparam int GW = dsfg_pkg::GAIN_W;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [IW-1:0]        IDX_MAX = {IW{1'b1}};

  function automatic logic signed [SW-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > PW'(SMAX)) begin
      r = SMAX;
    end else if (v < PW'(SMIN)) begin
      r = SMIN;
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // configuration
  logic                 hp_enable_r, gate_enable_r;
  logic [CW-1:0]        hp_coeff_r, lp_coeff_r, shelf_gain_r;
  logic [IW-1:0]        gate_start_r, gate_end_r;
  logic [dsfg_pkg::STEP_W-1:0] gate_step_r;

  // filter state
  logic signed [SW-1:0] hp_prev_in_r, hp_prev_out_r, shelf_lp_r;
  logic [IW-1:0]        sample_index_r;

  // per-sample working registers
  dsfg_pkg::state_t     state_r, state_nxt;
  logic signed [SW-1:0] x_r, h_r, s_r;
  logic                 first_r;
  logic [IW-1:0]        idx_r;
  logic [GW-1:0]        g_r;
  logic                 gate_on_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] out_data_r;

  // shared multiplier
  logic                 mul_en;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  logic                 in_fire, out_free;
  logic [IW-1:0]        idx_acc, idx_diff;
  logic signed [SW-1:0] hp_val, lp_val;

  dsfg_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  assign cfg_ch.ready   = 1'b1;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.sample_out = out_data_r;
  assign in_ch.ready    = (state_r == dsfg_pkg::S_IDLE);
  assign in_fire        = in_ch.valid && in_ch.ready;
  assign out_free       = !out_valid_r || out_ch.ready;
  assign idx_acc        = in_ch.first ? '0 : sample_index_r;
  assign idx_diff       = idx_r - gate_start_r;
  assign hp_val         = first_r ? x_r : sat(mul_p >>> 16);
  assign lp_val         = first_r ? h_r : sat(PW'(shelf_lp_r) + (mul_p >>> 16));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dsfg_pkg::S_IDLE:   if (in_fire) state_nxt = dsfg_pkg::S_HP_MUL;
      dsfg_pkg::S_HP_MUL: state_nxt = dsfg_pkg::S_HP_ACC;
      dsfg_pkg::S_HP_ACC: state_nxt = dsfg_pkg::S_LP_MUL;
      dsfg_pkg::S_LP_MUL: state_nxt = dsfg_pkg::S_LP_ACC;
      dsfg_pkg::S_LP_ACC: state_nxt = dsfg_pkg::S_SH_MUL;
      dsfg_pkg::S_SH_MUL: state_nxt = dsfg_pkg::S_SH_ACC;
      dsfg_pkg::S_SH_ACC: state_nxt = dsfg_pkg::S_GD_MUL;
      dsfg_pkg::S_GD_MUL: state_nxt = dsfg_pkg::S_GD_ACC;
      dsfg_pkg::S_GD_ACC: state_nxt = dsfg_pkg::S_GG_MUL;
      dsfg_pkg::S_GG_MUL: state_nxt = dsfg_pkg::S_GG_ACC;
      dsfg_pkg::S_GG_ACC: if (out_free) state_nxt = dsfg_pkg::S_IDLE;
      default:            state_nxt = dsfg_pkg::S_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      dsfg_pkg::S_HP_MUL: begin
        mul_en = 1'b1;
        mul_a  = AW'(hp_prev_out_r) + AW'(x_r) - AW'(hp_prev_in_r);
        mul_b  = signed'(BW'(hp_coeff_r));
      end
      dsfg_pkg::S_LP_MUL: begin
        mul_en = 1'b1;
        mul_a  = AW'(h_r) - AW'(shelf_lp_r);
        mul_b  = signed'(BW'(lp_coeff_r));
      end
      dsfg_pkg::S_SH_MUL: begin
        mul_en = 1'b1;
        mul_a  = AW'(h_r) - AW'(shelf_lp_r);
        mul_b  = signed'(BW'(shelf_gain_r));
      end
      dsfg_pkg::S_GD_MUL: begin
        // only meaningful once idx_r >= gate_start_r
        mul_en = 1'b1;
        mul_a  = signed'(AW'(idx_diff));
        mul_b  = signed'(BW'(gate_step_r));
      end
      dsfg_pkg::S_GG_MUL: begin
        mul_en = 1'b1;
        mul_a  = AW'(s_r);
        mul_b  = signed'(BW'(g_r));
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= dsfg_pkg::S_IDLE;
      out_valid_r    <= 1'b0;
      hp_enable_r    <= 1'b0;
      hp_coeff_r     <= dsfg_pkg::UNITY_Q16;
      lp_coeff_r     <= '0;
      shelf_gain_r   <= dsfg_pkg::UNITY_Q16;
      gate_enable_r  <= 1'b0;
      gate_start_r   <= '0;
      gate_end_r     <= '0;
      gate_step_r    <= '0;
      hp_prev_in_r   <= '0;
      hp_prev_out_r  <= '0;
      shelf_lp_r     <= '0;
      sample_index_r <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid && cfg_ch.ready) begin
        case (dsfg_pkg::cfg_reg_t'(cfg_ch.index))
          dsfg_pkg::REG_HP_ENABLE:   hp_enable_r   <= cfg_ch.data[0];
          dsfg_pkg::REG_HP_COEFF:    hp_coeff_r    <= cfg_ch.data[CW-1:0];
          dsfg_pkg::REG_LP_COEFF:    lp_coeff_r    <= cfg_ch.data[CW-1:0];
          dsfg_pkg::REG_SHELF_GAIN:  shelf_gain_r  <= cfg_ch.data[CW-1:0];
          dsfg_pkg::REG_GATE_ENABLE: gate_enable_r <= cfg_ch.data[0];
          dsfg_pkg::REG_GATE_START:  gate_start_r  <= cfg_ch.data[IW-1:0];
          dsfg_pkg::REG_GATE_END:    gate_end_r    <= cfg_ch.data[IW-1:0];
          dsfg_pkg::REG_GATE_STEP:   gate_step_r   <= cfg_ch.data[dsfg_pkg::STEP_W-1:0];
          default: begin
          end
        endcase
      end

      if (state_r == dsfg_pkg::S_GG_ACC && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        dsfg_pkg::S_IDLE: begin
          if (in_fire) begin
            x_r            <= in_ch.sample_in;
            first_r        <= in_ch.first;
            idx_r          <= idx_acc;
            sample_index_r <= (idx_acc < IDX_MAX) ? idx_acc + 1'b1 : IDX_MAX;
          end
        end
        dsfg_pkg::S_HP_ACC: begin
          hp_prev_in_r  <= x_r;
          hp_prev_out_r <= hp_val;
          h_r           <= hp_enable_r ? hp_val : x_r;
        end
        dsfg_pkg::S_LP_ACC: begin
          shelf_lp_r <= lp_val;
        end
        dsfg_pkg::S_SH_ACC: begin
          if (shelf_gain_r < dsfg_pkg::UNITY_Q16) begin
            s_r <= sat(PW'(shelf_lp_r) + (mul_p >>> 16));
          end else begin
            s_r <= h_r;
          end
        end
        dsfg_pkg::S_GD_ACC: begin
          gate_on_r <= gate_enable_r && (idx_r >= gate_start_r);
          if (idx_r >= gate_end_r || mul_p >= PW'(dsfg_pkg::UNITY_Q24)) begin
            g_r <= '0;
          end else begin
            g_r <= dsfg_pkg::UNITY_Q24 - mul_p[GW-1:0];
          end
        end
        dsfg_pkg::S_GG_ACC: begin
          if (out_free) begin
            out_data_r <= gate_on_r ? sat(mul_p >>> 24) : s_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A transaction on the input always starts the high-pass multiply.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == dsfg_pkg::S_HP_MUL)
    else $error("accepted sample did not start the sequence");

  // First sample of a buffer reseeds the high-pass: output equals input.
  a_first_seeds_hp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsfg_pkg::S_HP_ACC && first_r) |=> hp_prev_out_r == hp_prev_in_r)
    else $error("first sample did not seed high-pass state");

  // Sample index saturates instead of wrapping.
  a_index_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.first && sample_index_r == IDX_MAX) |=> sample_index_r == IDX_MAX)
    else $error("sample index wrapped");

  // Past both the gate start and the gate end with gating on, the result is silence.
  a_gate_mutes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dsfg_pkg::S_GG_ACC && out_free && gate_enable_r
     && idx_r >= gate_start_r && idx_r >= gate_end_r) |=> out_data_r == '0)
    else $error("gated tail not muted");

  // A held result is not overwritten before it is taken.
  a_out_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result overwritten");

endmodule

// ----- dv/dsfg_sb_pkg.sv -----
// Scoreboard for the sample filter and fade gate: predicts each output sample and checks it.
package dsfg_sb_pkg;
  import dsfg_pkg::*;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

  class filter_gate_scoreboard;
    // register copies
    logic               hp_en;
    logic [COEF_W-1:0]  hp_coeff;
    logic [COEF_W-1:0]  lp_coeff;
    logic [COEF_W-1:0]  shelf_gain;
    logic               gate_en;
    logic [INDEX_W-1:0] gate_start;
    logic [INDEX_W-1:0] gate_end;
    logic [STEP_W-1:0]  gate_step;
    // filter state
    longint             hp_prev_in;
    longint             hp_prev_out;
    longint             shelf_lp;
    logic [INDEX_W-1:0] sample_index;

    logic signed [SAMPLE_W-1:0] expected_samples[$];
    int                         mismatches;

    function new();
      hp_en = 1'b0;
      hp_coeff = UNITY_Q16;
      lp_coeff = '0;
      shelf_gain = UNITY_Q16;
      gate_en = 1'b0;
      gate_start = '0;
      gate_end = '0;
      gate_step = '0;
      hp_prev_in = 0;
      hp_prev_out = 0;
      shelf_lp = 0;
      sample_index = '0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] d);
      case (r)
        REG_HP_ENABLE:   hp_en = d[0];
        REG_HP_COEFF:    hp_coeff = d[COEF_W-1:0];
        REG_LP_COEFF:    lp_coeff = d[COEF_W-1:0];
        REG_SHELF_GAIN:  shelf_gain = d[COEF_W-1:0];
        REG_GATE_ENABLE: gate_en = d[0];
        REG_GATE_START:  gate_start = d[INDEX_W-1:0];
        REG_GATE_END:    gate_end = d[INDEX_W-1:0];
        REG_GATE_STEP:   gate_step = d[STEP_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return v;
    endfunction

    function logic signed [SAMPLE_W-1:0] filter_and_gate(logic signed [SAMPLE_W-1:0] smp,
                                                         logic first_flag);
      longint             x;
      longint             hp;
      longint             h;
      longint             lp;
      longint             s;
      longint             g;
      longint             dec;
      logic [INDEX_W-1:0] idx;
      x = smp;
      if (first_flag) hp = x;
      else hp = clamp((longint'(hp_coeff) * (hp_prev_out + x - hp_prev_in)) >>> 16);
      hp_prev_in = x;
      hp_prev_out = hp;
      h = hp_en ? hp : x;

      if (first_flag) lp = h;
      else lp = clamp(shelf_lp + ((longint'(lp_coeff) * (h - shelf_lp)) >>> 16));
      shelf_lp = lp;
      if (shelf_gain < UNITY_Q16) s = clamp(lp + ((longint'(shelf_gain) * (h - lp)) >>> 16));
      else s = h;

      idx = first_flag ? '0 : sample_index;
      sample_index = (idx < INDEX_MAX) ? idx + 1'b1 : INDEX_MAX;
      if (gate_en && idx >= gate_start) begin
        if (idx >= gate_end) begin
          g = 0;
        end else begin
          dec = (longint'(idx) - longint'(gate_start)) * longint'(gate_step);
          g = (dec >= longint'(UNITY_Q24)) ? 0 : longint'(UNITY_Q24) - dec;
        end
        s = clamp((s * g) >>> 24);
      end
      return s[SAMPLE_W-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic first_flag);
      expected_samples.insert(expected_samples.size(), filter_and_gate(smp, first_flag));
    endfunction

    function void check_sample(logic signed [SAMPLE_W-1:0] act);
      logic signed [SAMPLE_W-1:0] exp_smp;
      if (expected_samples.size() == 0) begin
        $error("sample_out: no transaction expected, actual %0d", act);
        mismatches++;
        return;
      end
      exp_smp = expected_samples.pop_front();
      if (act !== exp_smp) begin
        $error("sample_out: expected %0d, actual %0d", exp_smp, act);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_top.sv -----
// Top-level testbench for the drum sample filter and fade gate unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dsfg_pkg::*;
  import dsfg_sb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic               hp_en;
    logic [COEF_W-1:0]  hp_coeff;
    logic [COEF_W-1:0]  lp_coeff;
    logic [COEF_W-1:0]  shelf_gain;
    logic               gate_en;
    logic [INDEX_W-1:0] gate_start;
    logic [INDEX_W-1:0] gate_end;
    logic [STEP_W-1:0]  gate_step;
  } gate_cfg_t;

  logic clk;
  logic rst_n;

  dsfg_in_if  in_ch();
  dsfg_out_if out_ch();
  dsfg_cfg_if cfg_ch();

  drum_sample_filter_and_fade_gate_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  filter_gate_scoreboard sb = new();

  logic sender_steady = 1'b0;
  int   results_seen = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   stall_cycles = 0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // result side: random backpressure, one long hold, one stretch always ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_sample(out_ch.sample_out);
        results_seen++;
      end
      if (results_seen == 300 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (results_seen >= 800 && results_seen < 1000) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // leaves valid high; the caller lowers it after the last register
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(r, d);
  endtask

  task automatic configure(input gate_cfg_t c);
    write_reg(REG_HP_ENABLE, CFG_W'(c.hp_en));
    write_reg(REG_HP_COEFF, CFG_W'(c.hp_coeff));
    write_reg(REG_LP_COEFF, CFG_W'(c.lp_coeff));
    write_reg(REG_SHELF_GAIN, CFG_W'(c.shelf_gain));
    write_reg(REG_GATE_ENABLE, CFG_W'(c.gate_en));
    write_reg(REG_GATE_START, CFG_W'(c.gate_start));
    write_reg(REG_GATE_END, CFG_W'(c.gate_end));
    write_reg(REG_GATE_STEP, CFG_W'(c.gate_step));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic first_flag);
    if (!sender_steady) begin
      while ($urandom_range(99) < 8) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= smp;
    in_ch.first     <= first_flag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(smp, first_flag);
  endtask

  // registers change only with nothing in flight
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_coeff(input logic [COEF_W-1:0] typical);
    case ($urandom_range(5))
      0: return '0;
      1: return UNITY_Q16;
      2: return '1;
      3: return COEF_W'($urandom_range(131071));
      default: return typical;
    endcase
  endfunction

  function automatic gate_cfg_t rand_config();
    gate_cfg_t c;
    int        span;
    c.hp_en      = $urandom_range(1);
    c.hp_coeff   = pick_coeff(COEF_W'($urandom_range(65536, 50000)));
    c.lp_coeff   = pick_coeff(COEF_W'($urandom_range(30000, 100)));
    c.shelf_gain = pick_coeff(COEF_W'($urandom_range(65535)));
    c.gate_en    = ($urandom_range(3) != 0);
    if ($urandom_range(9) == 0) begin
      c.gate_start = INDEX_W'($urandom);
      c.gate_end   = INDEX_W'($urandom);
    end else begin
      c.gate_start = INDEX_W'($urandom_range(30));
      if ($urandom_range(7) == 0) c.gate_end = INDEX_W'($urandom_range(30));
      else c.gate_end = c.gate_start + INDEX_W'($urandom_range(60));
    end
    span = int'(c.gate_end) - int'(c.gate_start);
    case ($urandom_range(4))
      0: c.gate_step = '0;
      1: c.gate_step = '1;
      2: c.gate_step = STEP_W'($urandom);
      default: c.gate_step = (span > 0) ? STEP_W'((32'd1 << 24) / span) : STEP_W'($urandom);
    endcase
    return c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int kind,
                                                            input logic signed [SAMPLE_W-1:0] prev);
    longint v;
    case (kind)
      0: return SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(4))
          0: return SAMPLE_W'(SAMPLE_MAX);
          1: return SAMPLE_W'(SAMPLE_MIN);
          2: return '0;
          3: return '1;
          default: return SAMPLE_W'(1);
        endcase
      end
      2: return SAMPLE_W'(int'($urandom_range(4000)) - 2000);
      default: begin
        // slowly moving signal, which the filters treat very differently from noise
        v = longint'(prev) + longint'($urandom_range(200000)) - 100000;
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return SAMPLE_W'(v);
      end
    endcase
  endfunction

  initial begin
    gate_cfg_t                  c;
    int                         n;
    int                         phase_end;
    int                         len;
    int                         kind;
    logic                       cont;
    logic signed [SAMPLE_W-1:0] smp;

    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.sample_in  = '0;
    in_ch.first      = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_HP_ENABLE;
    cfg_ch.data      = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults, no start flag straight after reset
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
    send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_sample('1, 1'b0);
    send_sample(SAMPLE_W'(123456), 1'b1);
    send_sample('0, 1'b0);
    drain();

    // indexes below, at and inside the fade, then muted
    c = '{1'b1, UNITY_Q16, UNITY_Q16, '0, 1'b1, INDEX_W'(2), INDEX_W'(6), STEP_W'(4194304)};
    configure(c);
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b1);
    send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
    send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_sample(SAMPLE_W'(1000), 1'b0);
    send_sample(-SAMPLE_W'(1000), 1'b0);
    send_sample(SAMPLE_W'(5), 1'b0);
    send_sample(SAMPLE_W'(7), 1'b0);
    drain();

    // oversized coefficients saturate; gate end below gate start mutes from start on
    c = '{1'b1, '1, '1, UNITY_Q16 - 1'b1, 1'b1, INDEX_W'(3), INDEX_W'(1), '1};
    configure(c);
    send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b1);
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
    send_sample(SAMPLE_W'(SAMPLE_MIN), 1'b0);
    send_sample(SAMPLE_W'(SAMPLE_MAX), 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_W'(1), 1'b0);
    drain();

    // shelf gain above unity is bypass; fade gain floors at zero
    c = '{1'b0, '0, '0, '1, 1'b1, '0, INDEX_W'(20), '1};
    configure(c);
    send_sample(SAMPLE_W'(4000000), 1'b1);
    send_sample(SAMPLE_W'(4000000), 1'b0);
    send_sample(SAMPLE_W'(4000000), 1'b0);
    send_sample(-SAMPLE_W'(4000000), 1'b0);
    drain();

    n = 0;
    smp = '0;
    while (n < 1250) begin
      configure(rand_config());
      phase_end = n + 100 + $urandom_range(50);
      if (phase_end > 1250) phase_end = 1250;
      while (n < phase_end) begin
        len = ($urandom_range(9) == 0) ? 1 + $urandom_range(120) : 1 + $urandom_range(40);
        cont = ($urandom_range(9) == 0);
        kind = $urandom_range(3);
        for (int k = 0; k < len && n < phase_end; k++) begin
          sender_steady = (n >= 500 && n < 750);
          smp = pick_sample(($urandom_range(9) == 0) ? $urandom_range(3) : kind, smp);
          send_sample(smp, (k == 0) && !cont);
          n++;
        end
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
